// File: rtl/dttf_pkg.sv
package dttf_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned IntW     = 31;
  localparam int unsigned FracW    = 32;
  localparam int unsigned FracPosW = 5;
  localparam int unsigned ValueW   = 64;

  typedef logic [ChW-1:0]      ch_t;
  typedef logic [IntW-1:0]     int_acc_t;
  typedef logic [FracW-1:0]    frac_acc_t;
  typedef logic [FracPosW-1:0] frac_pos_t;
  typedef logic signed [ValueW-1:0] value_t;

  // Character codes
  localparam ch_t CharNul   = 8'h00;
  localparam ch_t CharZero  = 8'h30;
  localparam ch_t CharNine  = 8'h39;
  localparam ch_t CharPoint = 8'h2E;
  localparam ch_t CharMinus = 8'h2D;

  // Fraction digits actually summed (1..19)
  localparam frac_pos_t FracDigits = 5'd10;

  localparam int_acc_t  IntMax  = {IntW{1'b1}};
  localparam frac_acc_t FracMax = {FracW{1'b1}};

  // floor(2^32 / 10^(k+1)), Q0.32; zero from the tenth place on
  function automatic frac_acc_t recip(input frac_pos_t k);
    frac_acc_t r;
    case (k)
      5'd0:    r = 32'd429496729;
      5'd1:    r = 32'd42949672;
      5'd2:    r = 32'd4294967;
      5'd3:    r = 32'd429496;
      5'd4:    r = 32'd42949;
      5'd5:    r = 32'd4294;
      5'd6:    r = 32'd429;
      5'd7:    r = 32'd42;
      5'd8:    r = 32'd4;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/dttf_in_if.sv
interface dttf_in_if;
  logic          valid;
  logic          ready;
  dttf_pkg::ch_t ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// File: rtl/dttf_out_if.sv
interface dttf_out_if;
  logic             valid;
  logic             ready;
  dttf_pkg::value_t value;
  logic             overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

// File: rtl/decimal_text_to_fixed_parser.sv
// Decimal text to signed Q31.32 fixed-point parser.
// in_i carries one character byte per transfer. Digits before the first '.'
// build the integer part (saturating at 2^31-1, flagged by overflow); up to
// FracDigits digits after it add digit * floor(2^32/10^k). A leading '-'
// negates; every other character is ignored. A NUL byte ends the string and
// produces one transfer on out_o with value and overflow, then the parser
// state returns to its start-of-string values.
// Timing: a character is registered at the input and the accumulators
// update from the input register; for a NUL the result register is loaded
// from the accumulators as they clear, once the output register is free.
// Throughput: one character per cycle unless a NUL waits on a full output
// register; the x10 shift-add and 4x32 table multiply with add are combinational.
// Stall: while a result waits in the output register, non-NUL characters
// keep flowing; a following NUL waits in the input register until the
// result is taken, which then holds in_i.ready low.
// Reset (rst_ni low, asynchronous): both registers empty, accumulators
// cleared, parser at the start of a string.
module decimal_text_to_fixed_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  dttf_in_if.sink    in_i,
  dttf_out_if.source out_o
);

  // Input register
  logic          in_valid_q, in_valid_d;
  dttf_pkg::ch_t ch_q;

  // Parser state
  dttf_pkg::int_acc_t  int_acc_q, int_acc_d;
  dttf_pkg::frac_acc_t frac_acc_q, frac_acc_d;
  dttf_pkg::frac_pos_t frac_pos_q, frac_pos_d;
  logic in_fraction_q, in_fraction_d;
  logic is_negative_q, is_negative_d;
  logic at_first_q, at_first_d;
  logic sat_q, sat_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  dttf_pkg::value_t value_q, value_d;
  logic             overflow_q;

  logic        is_nul, is_digit, fire, fire_nul, out_free;
  logic [3:0]  digit;
  logic [34:0] int_next;
  logic [35:0] frac_prod;
  logic [36:0] frac_sum;
  logic [63:0] mag;

  assign is_nul   = (ch_q == dttf_pkg::CharNul);
  assign out_free = !out_valid_q || out_o.ready;
  // a NUL needs a free result slot; anything else always proceeds
  assign fire     = in_valid_q && (!is_nul || out_free);
  assign fire_nul = fire && is_nul;

  assign in_i.ready = !in_valid_q || fire;
  assign in_valid_d = in_i.valid ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  assign is_digit = (ch_q >= dttf_pkg::CharZero) && (ch_q <= dttf_pkg::CharNine);
  assign digit    = 4'(ch_q - dttf_pkg::CharZero);

  // x10 as (x << 3) + (x << 1)
  assign int_next  = {1'b0, int_acc_q, 3'b000} + {3'b000, int_acc_q, 1'b0}
                   + {31'd0, digit};
  assign frac_prod = 36'(digit) * 36'(dttf_pkg::recip(frac_pos_q));
  assign frac_sum  = {5'd0, frac_acc_q} + {1'b0, frac_prod};

  always_comb begin
    int_acc_d     = int_acc_q;
    frac_acc_d    = frac_acc_q;
    frac_pos_d    = frac_pos_q;
    in_fraction_d = in_fraction_q;
    is_negative_d = is_negative_q;
    at_first_d    = at_first_q;
    sat_d         = sat_q;
    if (fire) begin
      if (is_nul) begin
        int_acc_d     = '0;
        frac_acc_d    = '0;
        frac_pos_d    = '0;
        in_fraction_d = 1'b0;
        is_negative_d = 1'b0;
        at_first_d    = 1'b1;
        sat_d         = 1'b0;
      end else begin
        if (is_digit) begin
          if (!in_fraction_q) begin
            if (int_next > 35'(dttf_pkg::IntMax)) begin
              int_acc_d = dttf_pkg::IntMax;
              sat_d     = 1'b1;
            end else begin
              int_acc_d = int_next[30:0];
            end
          end else if (frac_pos_q < dttf_pkg::FracDigits) begin
            frac_acc_d = (frac_sum > 37'(dttf_pkg::FracMax)) ? dttf_pkg::FracMax
                                                             : frac_sum[31:0];
            frac_pos_d = frac_pos_q + 5'd1;
          end
        end else if (ch_q == dttf_pkg::CharPoint) begin
          in_fraction_d = 1'b1;
        end else if ((ch_q == dttf_pkg::CharMinus) && at_first_q) begin
          is_negative_d = 1'b1;
        end
        at_first_d = 1'b0;
      end
    end
  end

  // Result: magnitude int.frac, two's complement negate if '-' led
  assign mag         = {1'b0, int_acc_q, frac_acc_q};
  assign value_d     = is_negative_q ? -$signed(mag) : $signed(mag);
  assign out_valid_d = fire_nul ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      int_acc_q     <= '0;
      frac_acc_q    <= '0;
      frac_pos_q    <= '0;
      in_fraction_q <= 1'b0;
      is_negative_q <= 1'b0;
      at_first_q    <= 1'b1;
      sat_q         <= 1'b0;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      int_acc_q     <= int_acc_d;
      frac_acc_q    <= frac_acc_d;
      frac_pos_q    <= frac_pos_d;
      in_fraction_q <= in_fraction_d;
      is_negative_q <= is_negative_d;
      at_first_q    <= at_first_d;
      sat_q         <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q <= in_i.ch;
    end
    if (fire_nul) begin
      value_q    <= value_d;
      overflow_q <= sat_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = value_q;
  assign out_o.overflow = overflow_q;

  // Assertions
  a_nul_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_nul |=> out_valid_q)
    else $error("NUL did not produce a result");

  a_frac_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_pos_q <= dttf_pkg::FracDigits)
    else $error("fraction position past limit");

  a_frac_only_after_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fraction_q |-> (frac_acc_q == '0 && frac_pos_q == '0))
    else $error("fraction accumulated before point");

  a_sat_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> int_acc_q == dttf_pkg::IntMax)
    else $error("saturation flag without saturated integer");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_first_q |-> (!is_negative_q && !in_fraction_q && !sat_q && int_acc_q == '0))
    else $error("state not clear at start of string");

endmodule

// File: tb/decimal_text_to_fixed_parser_test.sv
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser_test;
  import dttf_pkg::*;

  // Long receiver hold-off and the stall watchdog limit, in clock cycles.
  // The limit covers the hold-off plus a sender gap and a receiver stall.
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned RandomChars  = 1450;
  localparam int unsigned TotalChars   = 1800;

  // Parser prediction and result checking. Every accepted character is fed
  // to note_char(); a NUL queues the Q31.32 value the block must return.
  class parse_scoreboard;
    typedef struct {
      value_t value;
      logic   overflow;
    } parsed_t;

    parsed_t     expected_q[$];
    int_acc_t    int_part;
    frac_acc_t   frac_part;
    bit          point_seen;
    frac_pos_t   frac_count;
    bit          negate;
    bit          first_char;
    bit          saturated;
    int unsigned errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      int_part   = '0;
      frac_part  = '0;
      point_seen = 1'b0;
      frac_count = '0;
      negate     = 1'b0;
      first_char = 1'b1;
      saturated  = 1'b0;
    endfunction

    // Weight of the k-th fraction place: floor(2^32 / 10^k), Q0.32
    function frac_acc_t place_weight(int unsigned k);
      bit [63:0] pow10;
      pow10 = 64'd1;
      for (int unsigned i = 0; i < k; i++) pow10 = pow10 * 64'd10;
      return frac_acc_t'(64'h1_0000_0000 / pow10);
    endfunction

    function void note_char(ch_t c);
      bit [63:0] wide;
      bit [63:0] mag;
      bit [63:0] digit;
      parsed_t   res;
      if (c == CharNul) begin
        mag          = {1'b0, int_part, frac_part};
        res.value    = negate ? value_t'(64'd0 - mag) : value_t'(mag);
        res.overflow = saturated;
        expected_q.push_back(res);
        clear();
        return;
      end
      if (c >= CharZero && c <= CharNine) begin
        digit = 64'(c - CharZero);
        if (!point_seen) begin
          wide = 64'(int_part) * 64'd10 + digit;
          if (wide > 64'(IntMax)) begin
            int_part  = IntMax;
            saturated = 1'b1;
          end else begin
            int_part = int_acc_t'(wide);
          end
        end else if (frac_count < FracDigits) begin
          wide = 64'(frac_part) + digit * 64'(place_weight(int'(frac_count) + 1));
          frac_part  = (wide > 64'(FracMax)) ? FracMax : frac_acc_t'(wide);
          frac_count = frac_count + 1'b1;
        end
      end else if (c == CharPoint) begin
        point_seen = 1'b1;
      end else if (c == CharMinus && first_char) begin
        negate = 1'b1;
      end
      first_char = 1'b0;
    endfunction

    function void check_result(value_t value, logic overflow);
      parsed_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d overflow=%0b", $time, value, overflow);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, exp_res.value, value);
        errors++;
      end
      if (overflow !== exp_res.overflow) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, exp_res.overflow, overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  dttf_in_if  in_if ();
  dttf_out_if out_if ();

  decimal_text_to_fixed_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  parse_scoreboard book = new();

  // Idle controls shared by the sender and receiver processes
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned chars_sent  = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: results are checked before the same-edge input transfer is
  // noted, so a result can only match an expectation queued on an earlier
  // edge. The watchdog counts edges with no transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) book.check_result(out_if.value, out_if.overflow);
      if (in_if.valid && in_if.ready) book.note_char(in_if.ch);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts while enabled, one long hold-off on
  // request so that the output register fills and the input backs up.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // One character transfer, with an optional idle burst ahead of it.
  // valid stays high between back-to-back characters.
  task automatic send_char(input ch_t c);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk_i); while (!in_if.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(ch_t'(s[i]));
    send_char(CharNul);
  endtask

  function automatic ch_t rand_digit();
    return ch_t'(CharZero + $urandom_range(0, 9));
  endfunction

  // Any non-NUL byte, biased toward the characters the parser reacts to
  function automatic ch_t rand_noise();
    case ($urandom_range(0, 3))
      0:       return CharMinus;
      1:       return CharPoint;
      2:       return rand_digit();
      default: return ch_t'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly well-formed numbers with random content: sign, integer digits
  // (sometimes enough to saturate), point and fraction digits (sometimes
  // past the summed places). The rest are broken or noisy strings.
  task automatic send_random_string();
    int unsigned n_int;
    int unsigned n_frac;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 8)) send_char(rand_noise());
    end else begin
      if ($urandom_range(0, 1)) send_char(CharMinus);
      n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
      repeat (n_int) send_char(rand_digit());
      if ($urandom_range(0, 9) == 0) send_char(rand_noise());
      if ($urandom_range(0, 3) != 0) begin
        send_char(CharPoint);
        n_frac = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14)
                                              : $urandom_range(0, 6);
        repeat (n_frac) send_char(rand_digit());
        // second point followed by digits that must still count
        if ($urandom_range(0, 9) == 0) begin
          send_char(CharPoint);
          repeat ($urandom_range(1, 3)) send_char(rand_digit());
        end
      end
    end
    send_char(CharNul);
  endtask

  initial begin
    int unsigned n_strings;
    in_if.valid <= 1'b0;
    in_if.ch    <= CharNul;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty string, negative zero, late minus / second point /
    // ignored bytes, and a saturating integer with extra fraction digits.
    send_char(CharNul);
    send_text("-0");
    send_text("3-.5.5");
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CharNul);
    send_text("-99999999999.09999999999");

    // Random strings; idling on each side is drawn anew at random every 12
    // strings so that stretches without gaps show up as well.
    n_strings = 0;
    while (chars_sent < RandomChars) begin
      if (n_strings % 12 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_random_string();
      n_strings++;
    end

    // Back-pressure: receiver holds off while short strings keep coming,
    // filling the output and input registers until in_i stalls.
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (12) begin
      case ($urandom_range(0, 2))
        0:       send_text("7");
        1:       send_text(".25");
        default: send_text("-1");
      endcase
    end

    // Final stretch with no idling on either side
    rx_idle_en = 1'b0;
    while (chars_sent < TotalChars) send_random_string();

    in_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    // drain margin before the final verdict
    repeat (8) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dttf_pkg.sv
rtl/dttf_in_if.sv
rtl/dttf_out_if.sv
rtl/decimal_text_to_fixed_parser.sv
tb/decimal_text_to_fixed_parser_test.sv
